### design/tcc_pkg.sv
// ----------------------------------------------------------------------------
// Tetrahedron circumcentre package
// Constants shared by the circumcentre pipeline and its multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

	// Width of one multiplier operand digit consumed per pipeline stage.
	localparam int MUL_DIGIT = 16;

	// Occupancy codes of the two-entry output skid buffer.
	localparam logic [1:0] SKID_EMPTY = 2'd0;
	localparam logic [1:0] SKID_ONE   = 2'd1;
	localparam logic [1:0] SKID_FULL  = 2'd2;

endpackage

`default_nettype wire

### design/tcc_vtx_if.sv
// ----------------------------------------------------------------------------
// Vertex channel
// Valid/ready channel carrying the four vertices of one tetrahedron.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_vtx_if #(
	parameter int COORD_WIDTH = 32
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] p0_x;
	logic signed [COORD_WIDTH-1:0] p0_y;
	logic signed [COORD_WIDTH-1:0] p0_z;
	logic signed [COORD_WIDTH-1:0] p1_x;
	logic signed [COORD_WIDTH-1:0] p1_y;
	logic signed [COORD_WIDTH-1:0] p1_z;
	logic signed [COORD_WIDTH-1:0] p2_x;
	logic signed [COORD_WIDTH-1:0] p2_y;
	logic signed [COORD_WIDTH-1:0] p2_z;
	logic signed [COORD_WIDTH-1:0] p3_x;
	logic signed [COORD_WIDTH-1:0] p3_y;
	logic signed [COORD_WIDTH-1:0] p3_z;

	modport source (
		output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
		p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
		input ready
	);

	modport sink (
		input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
		p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
		output ready
	);
endinterface

`default_nettype wire

### design/tcc_ctr_if.sv
// ----------------------------------------------------------------------------
// Centre channel
// Valid/ready channel carrying one circumcentre and its degenerate flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_ctr_if #(
	parameter int COORD_WIDTH = 32
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] centre_x;
	logic signed [COORD_WIDTH-1:0] centre_y;
	logic signed [COORD_WIDTH-1:0] centre_z;
	logic degenerate;

	modport source (
		output valid, centre_x, centre_y, centre_z, degenerate,
		input ready
	);

	modport sink (
		input valid, centre_x, centre_y, centre_z, degenerate,
		output ready
	);
endinterface

`default_nettype wire

### design/tetrahedron_circumcentre_unit.sv
// ----------------------------------------------------------------------------
// Tetrahedron circumcentre unit
// Computes the centre of the sphere through four vertices given in signed
// fixed point, rounding the quotient to nearest, saturating the result and
// flagging flat tetrahedra.
// ----------------------------------------------------------------------------
//
//  Channel | Side   | Handshake    | Word contents
//  --------+--------+--------------+------------------------------------------
//  vtx     | sink   | valid/ready  | p0_x .. p3_z, COORD_WIDTH bits each
//  ctr     | source | valid/ready  | centre_x/y/z, COORD_WIDTH bits; degenerate
//
//  One word is accepted every cycle unless the skid buffer is full. The
//  pipeline depth is set mostly by the restoring
//  divider, which resolves one quotient bit per pipeline stage.
//  Reset clears the stage valid bits and the skid occupancy only.
//  The pipeline holds only while two finished words wait in the skid buffer.
//
`default_nettype none

module tetrahedron_circumcentre_unit #(
	parameter int COORD_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	tcc_vtx_if.sink  vtx,
	tcc_ctr_if.source ctr
);

	localparam int W      = COORD_WIDTH;
	localparam int DW     = W + 1;
	localparam int PAW    = 2 * DW;
	localparam int SQW    = 2 * W + 4;
	localparam int CRW    = 2 * W + 3;
	localparam int PBW    = CRW + SQW;
	localparam int SW     = PBW + 2;
	localparam int QB     = W + 2;
	localparam int RW     = SW + QB;
	localparam int DIG    = tcc_pkg::MUL_DIGIT;
	localparam int LA     = (DW + DIG - 1) / DIG;
	localparam int LB     = (SQW + DIG - 1) / DIG;
	localparam int S_CR   = 2 + LA;
	localparam int S_SUM  = S_CR + LB + 1;
	localparam int S_DIV0 = S_SUM + 3;
	localparam int L      = S_DIV0 + QB;
	localparam int OW     = 3 * W + 1;

	logic [1:0] cnt_q;
	logic       en;
	logic       accept;
	logic       push;
	logic       pop;

	assign en        = (cnt_q != tcc_pkg::SKID_FULL);
	assign vtx.ready = en;
	assign accept    = vtx.valid && en;

	logic v_s [1:L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= L; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s[1] <= accept;
			for (int i = 2; i <= L; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	logic signed [W-1:0] pin [4][3];

	assign pin[0][0] = vtx.p0_x;
	assign pin[0][1] = vtx.p0_y;
	assign pin[0][2] = vtx.p0_z;
	assign pin[1][0] = vtx.p1_x;
	assign pin[1][1] = vtx.p1_y;
	assign pin[1][2] = vtx.p1_z;
	assign pin[2][0] = vtx.p2_x;
	assign pin[2][1] = vtx.p2_y;
	assign pin[2][2] = vtx.p2_z;
	assign pin[3][0] = vtx.p3_x;
	assign pin[3][1] = vtx.p3_y;
	assign pin[3][2] = vtx.p3_z;

	// Edge vectors from vertex 0.
	logic signed [DW-1:0]  d_s1  [3][3];
	logic        [3*W-1:0] p0_s  [1:L];
	logic signed [DW-1:0]  d0_s  [2:S_CR][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int c = 0; c < 3; c++) begin
					d_s1[k][c] <= DW'(pin[k+1][c]) - DW'(pin[0][c]);
				end
			end
			p0_s[1] <= {pin[0][0], pin[0][1], pin[0][2]};
			for (int i = 2; i <= L; i++) begin
				p0_s[i] <= p0_s[i-1];
			end
			for (int c = 0; c < 3; c++) begin
				d0_s[2][c] <= d_s1[0][c];
				for (int i = 3; i <= S_CR; i++) begin
					d0_s[i][c] <= d0_s[i-1][c];
				end
			end
		end
	end

	logic signed [PAW-1:0] pa_w  [3][3];
	logic signed [PAW-1:0] pb_w  [3][3];
	logic signed [PAW-1:0] sqp_w [3][3];
	logic signed [SQW-1:0] sq_s  [3];
	logic signed [CRW-1:0] cr_s  [3][3];

	genvar j, c;
	generate
		for (j = 0; j < 3; j++) begin : g_pair
			for (c = 0; c < 3; c++) begin : g_comp
				tcc_mul #(.AW(DW), .BW(DW)) u_mul_pa (
					.clk (clk),
					.en  (en),
					.a   (d_s1[(j+1)%3][(c+1)%3]),
					.b   (d_s1[(j+2)%3][(c+2)%3]),
					.p   (pa_w[j][c])
				);
				tcc_mul #(.AW(DW), .BW(DW)) u_mul_pb (
					.clk (clk),
					.en  (en),
					.a   (d_s1[(j+1)%3][(c+2)%3]),
					.b   (d_s1[(j+2)%3][(c+1)%3]),
					.p   (pb_w[j][c])
				);
				tcc_mul #(.AW(DW), .BW(DW)) u_mul_sq (
					.clk (clk),
					.en  (en),
					.a   (d_s1[j][c]),
					.b   (d_s1[j][c]),
					.p   (sqp_w[j][c])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s[k] <= SQW'(sqp_w[k][0]) + SQW'(sqp_w[k][1]) + SQW'(sqp_w[k][2]);
				for (int m = 0; m < 3; m++) begin
					cr_s[k][m] <= CRW'(pa_w[k][m]) - CRW'(pb_w[k][m]);
				end
			end
		end
	end

	logic signed [PBW-1:0] nt_w [3][3];
	logic signed [PBW-1:0] dt_w [3];

	generate
		for (j = 0; j < 3; j++) begin : g_num
			for (c = 0; c < 3; c++) begin : g_comp
				tcc_mul #(.AW(CRW), .BW(SQW)) u_mul_n (
					.clk (clk),
					.en  (en),
					.a   (cr_s[j][c]),
					.b   (sq_s[j]),
					.p   (nt_w[j][c])
				);
			end
		end
		for (c = 0; c < 3; c++) begin : g_det
			tcc_mul #(.AW(CRW), .BW(SQW)) u_mul_d (
				.clk (clk),
				.en  (en),
				.a   (cr_s[0][c]),
				.b   (SQW'(d0_s[S_CR][c])),
				.p   (dt_w[c])
			);
		end
	endgenerate

	logic signed [SW-1:0] n_s   [3];
	logic signed [SW-1:0] det_s;
	logic        [SW-1:0] an_s  [3];
	logic        [SW-1:0] dmag_s;
	logic                 neg_a_s [3];
	logic                 zero_a_s;
	logic        [SW-1:0] num_s [3];
	logic        [SW-1:0] den_n_s;
	logic                 neg_n_s [3];
	logic                 zero_n_s;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 3; m++) begin
				n_s[m] <= SW'(nt_w[0][m]) + SW'(nt_w[1][m]) + SW'(nt_w[2][m]);
			end
			det_s <= SW'(dt_w[0]) + SW'(dt_w[1]) + SW'(dt_w[2]);

			for (int m = 0; m < 3; m++) begin
				an_s[m]    <= n_s[m][SW-1] ? SW'(-n_s[m]) : SW'(n_s[m]);
				neg_a_s[m] <= n_s[m][SW-1] ^ det_s[SW-1];
			end
			dmag_s   <= det_s[SW-1] ? SW'(-det_s) : SW'(det_s);
			zero_a_s <= (det_s == '0);

			// Adding the magnitude of det before dividing by 2|det| rounds halves away.
			for (int m = 0; m < 3; m++) begin
				num_s[m]   <= an_s[m] + dmag_s;
				neg_n_s[m] <= neg_a_s[m];
			end
			den_n_s  <= dmag_s << 1;
			zero_n_s <= zero_a_s;
		end
	end

	logic [RW-1:0] rem_s  [0:QB][3];
	logic [QB-1:0] q_s    [0:QB][3];
	logic          ovf_s  [0:QB][3];
	logic          neg_s  [0:QB][3];
	logic [SW-1:0] den_s  [0:QB];
	logic          zero_s [0:QB];

	// A quotient of 2^(W+2) or more saturates whatever vertex 0 holds.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 3; m++) begin
				rem_s[0][m] <= RW'(num_s[m]);
				q_s[0][m]   <= '0;
				ovf_s[0][m] <= RW'(num_s[m]) >= (RW'(den_n_s) << QB);
				neg_s[0][m] <= neg_n_s[m];
			end
			den_s[0]  <= den_n_s;
			zero_s[0] <= zero_n_s;
		end
	end

	genvar i;
	generate
		for (i = 1; i <= QB; i++) begin : g_div
			localparam int B = QB - i;

			always_ff @(posedge clk) begin
				if (en) begin
					for (int m = 0; m < 3; m++) begin
						if (rem_s[i-1][m] >= (RW'(den_s[i-1]) << B)) begin
							rem_s[i][m] <= rem_s[i-1][m] - (RW'(den_s[i-1]) << B);
							q_s[i][m]   <= q_s[i-1][m] | (QB'(1) << B);
						end else begin
							rem_s[i][m] <= rem_s[i-1][m];
							q_s[i][m]   <= q_s[i-1][m];
						end
						ovf_s[i][m] <= ovf_s[i-1][m];
						neg_s[i][m] <= neg_s[i-1][m];
					end
					den_s[i]  <= den_s[i-1];
					zero_s[i] <= zero_s[i-1];
				end
			end
		end
	endgenerate

	logic signed [W-1:0] res [3];
	logic [OW-1:0]       res_word;

	always_comb begin
		logic signed [W+2:0] qv;
		logic signed [W+3:0] sum;
		logic signed [W+3:0] hi;
		logic signed [W+3:0] lo;
		logic signed [W-1:0] p0c;
		hi = (W+4)'((64'sd1 <<< (W - 1)) - 64'sd1);
		lo = -hi - (W+4)'(1);
		for (int m = 0; m < 3; m++) begin
			p0c = p0_s[L][(2-m)*W +: W];
			qv  = $signed((W+3)'(q_s[QB][m]));
			if (neg_s[QB][m]) begin
				qv = -qv;
			end
			sum = (W+4)'(p0c) + (W+4)'(qv);
			if (zero_s[QB]) begin
				res[m] = '0;
			end else if (ovf_s[QB][m]) begin
				res[m] = neg_s[QB][m] ? W'(lo) : W'(hi);
			end else if (sum > hi) begin
				res[m] = W'(hi);
			end else if (sum < lo) begin
				res[m] = W'(lo);
			end else begin
				res[m] = W'(sum);
			end
		end
		res_word = {res[0], res[1], res[2], zero_s[QB]};
	end

	// Two-entry skid buffer; slot0 drives the centre channel.
	logic [OW-1:0] slot0_q;
	logic [OW-1:0] slot1_q;

	assign push      = en && v_s[L];
	assign ctr.valid = (cnt_q != tcc_pkg::SKID_EMPTY);
	assign pop       = ctr.valid && ctr.ready;

	assign ctr.centre_x   = slot0_q[3*W -: W];
	assign ctr.centre_y   = slot0_q[2*W -: W];
	assign ctr.centre_z   = slot0_q[W -: W];
	assign ctr.degenerate = slot0_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= tcc_pkg::SKID_EMPTY;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			tcc_pkg::SKID_EMPTY: begin
				if (push) begin
					slot0_q <= res_word;
				end
			end
			tcc_pkg::SKID_ONE: begin
				if (push && pop) begin
					slot0_q <= res_word;
				end else if (push) begin
					slot1_q <= res_word;
				end
			end
			tcc_pkg::SKID_FULL: begin
				if (pop) begin
					slot0_q <= slot1_q;
				end
			end
			default: begin
				slot0_q <= slot0_q;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/tcc_mul.sv
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Consumes one digit of operand b per stage and accumulates the partial
// products; the accumulator of the last stage is the product.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [AW-1:0]      a,
	input  logic signed [BW-1:0]      b,
	output logic signed [AW+BW-1:0]   p
);

	localparam int DIG = tcc_pkg::MUL_DIGIT;
	localparam int NS  = (BW + DIG - 1) / DIG;
	localparam int PW  = AW + BW;

	logic signed [AW-1:0] a_s   [NS];
	logic signed [BW-1:0] b_s   [NS];
	logic signed [PW-1:0] acc_s [NS];

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_stage
			localparam int LO = k * DIG;
			localparam int DL = (k == NS - 1) ? (BW - LO) : DIG;

			logic signed [AW-1:0] a_in;
			logic signed [BW-1:0] b_in;
			logic signed [PW-1:0] acc_in;
			logic signed [DL:0]   dig;
			logic signed [AW+DL:0] prod;

			if (k == 0) begin : g_first
				assign a_in   = a;
				assign b_in   = b;
				assign acc_in = '0;
			end else begin : g_next
				assign a_in   = a_s[k-1];
				assign b_in   = b_s[k-1];
				assign acc_in = acc_s[k-1];
			end

			// The top digit carries the sign of b; the lower digits are unsigned.
			if (k == NS - 1) begin : g_top
				assign dig = {b_in[BW-1], b_in[LO+DL-1:LO]};
			end else begin : g_low
				assign dig = {1'b0, b_in[LO+DL-1:LO]};
			end

			assign prod = a_in * dig;

			always_ff @(posedge clk) begin
				if (en) begin
					a_s[k]   <= a_in;
					b_s[k]   <= b_in;
					acc_s[k] <= acc_in + (PW'(prod) <<< LO);
				end
			end
		end
	endgenerate

	assign p = acc_s[NS-1];

endmodule

`default_nettype wire

### design/tcc_checker.sv
// ----------------------------------------------------------------------------
// Circumcentre port checker
// Watches the channel ports of the circumcentre unit over time.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_checker #(
	parameter int COORD_WIDTH = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          vtx_ready,
	input logic                          ctr_valid,
	input logic                          ctr_ready,
	input logic signed [COORD_WIDTH-1:0] centre_x,
	input logic signed [COORD_WIDTH-1:0] centre_y,
	input logic signed [COORD_WIDTH-1:0] centre_z,
	input logic                          degenerate
);

	a_ctr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_valid && !ctr_ready |=> ctr_valid)
		else $error("centre word withdrawn while stalled");

	a_ctr_stable: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_valid && !ctr_ready |=> $stable({centre_x, centre_y, centre_z, degenerate}))
		else $error("centre word changed while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_valid && degenerate |-> centre_x == 0 && centre_y == 0 && centre_z == 0)
		else $error("flat tetrahedron gave a nonzero centre");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!ctr_valid |-> vtx_ready)
		else $error("vertex channel stalled with no centre word waiting");

endmodule

bind tetrahedron_circumcentre_unit tcc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.vtx_ready  (vtx.ready),
	.ctr_valid  (ctr.valid),
	.ctr_ready  (ctr.ready),
	.centre_x   (ctr.centre_x),
	.centre_y   (ctr.centre_y),
	.centre_z   (ctr.centre_z),
	.degenerate (ctr.degenerate)
);

`default_nettype wire
